FILE: rtl/mmrec_pkg.sv
package mmrec_pkg;

   // number of encoder channels held in the state array
   localparam int CHANNELS = 8;

   // channel field as it arrives on the port
   localparam int CH_FIELD_W = 3;
   // index width that the state array needs
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   // extended channel width, wide enough to compare against CHANNELS
   localparam int CH_EXT_W = ((CH_IDX_W > CH_FIELD_W) ? CH_IDX_W : CH_FIELD_W) + 1;

   localparam int COUNT_W = 32;
   localparam int TALLY_W = 16;
   localparam int MODE_W  = 2;

   // decode modes
   localparam logic [MODE_W-1:0] MODE_QUAD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RISE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DIR  = 2'd2;

   // item commands
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // transition codes {previous AB, current AB} that step up or down
   localparam logic [15:0] STEP_UP_MASK   = 16'h2814;
   localparam logic [15:0] STEP_DOWN_MASK = 16'h4182;

   localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

   typedef struct packed {
      logic                  cmd;
      logic [CH_FIELD_W-1:0] channel;
      logic                  level_a;
      logic                  level_b;
   } item_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [1:0]         levels;
      logic [TALLY_W-1:0] tally;
   } entry_type;

   typedef struct packed {
      logic [CH_FIELD_W-1:0] out_channel;
      logic [COUNT_W-1:0]    position;
      logic                  redundant;
      logic [TALLY_W-1:0]    repeats;
   } result_type;

endpackage

FILE: rtl/multi_mode_rotary_encoder_counter_core.sv
// Path: an accepted item enters the input register, then the result register, where
// rsp_valid rises; a stall on the result side can hold it in the input register.
// Throughput: one item per cycle while rsp_ready is high; the per-channel update is
// a mode decode and a 32-bit increment or decrement between the two registers.
// Reset: synchronous, active high; clears all channel counts, levels and tallies,
// sets the decode mode to 0 and empties both pipeline registers.
module multi_mode_rotary_encoder_counter_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [mmrec_pkg::CH_FIELD_W-1:0]  req_channel,
   input  logic                              req_level_a,
   input  logic                              req_level_b,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mmrec_pkg::CH_FIELD_W-1:0]  rsp_out_channel,
   output logic signed [mmrec_pkg::COUNT_W-1:0] rsp_position,
   output logic                              rsp_redundant,
   output logic [mmrec_pkg::TALLY_W-1:0]     rsp_repeats,
   input  logic                              csr_wr_en,
   input  logic [mmrec_pkg::MODE_W-1:0]      csr_wr_data
);
   import mmrec_pkg::*;

   logic [MODE_W-1:0] mode_ff;
   logic              stage_valid_ff;
   item_type          stage_item_ff;
   logic              rsp_valid_ff;
   result_type        rsp_ff;
   entry_type         state_ff [CHANNELS];

   logic                advance;
   logic [CH_EXT_W-1:0] stage_ch_ext;
   logic [CH_IDX_W-1:0] stage_idx;
   entry_type           old_entry;
   entry_type           new_entry;
   logic                entry_we;
   result_type          result;

   // move an item out of the input register when the result register frees up
   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;

   assign stage_ch_ext = CH_EXT_W'(stage_item_ff.channel);
   assign stage_idx    = stage_ch_ext[CH_IDX_W-1:0];
   assign old_entry    = state_ff[stage_idx];

   mmrec_update u_update (
      .item      (stage_item_ff),
      .mode      (mode_ff),
      .old_entry (old_entry),
      .new_entry (new_entry),
      .entry_we  (entry_we),
      .result    (result)
   );

   // hold the decode mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_QUAD;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // capture an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         stage_item_ff <= '{cmd: req_cmd, channel: req_channel,
                            level_a: req_level_a, level_b: req_level_b};
      end
   end

   // update the channel state as an in-range item advances
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            state_ff[i] <= '0;
         end
      end else if (advance && entry_we) begin
         state_ff[stage_idx] <= new_entry;
      end
   end

   // load the result register, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_ff.out_channel;
   assign rsp_position    = $signed(rsp_ff.position);
   assign rsp_redundant   = rsp_ff.redundant;
   assign rsp_repeats     = rsp_ff.repeats;

endmodule

FILE: rtl/mmrec_update.sv
module mmrec_update (
   input  mmrec_pkg::item_type   item,
   input  logic [1:0]            mode,
   input  mmrec_pkg::entry_type  old_entry,
   output mmrec_pkg::entry_type  new_entry,
   output logic                  entry_we,
   output mmrec_pkg::result_type result
);
   import mmrec_pkg::*;

   logic [CH_EXT_W-1:0] ch_ext;
   logic                in_range;
   logic [1:0]          cur_levels;
   logic [3:0]          code;
   logic                last_a;
   logic                red;

   assign ch_ext     = CH_EXT_W'(item.channel);
   assign in_range   = ch_ext < CH_EXT_W'(CHANNELS);
   assign cur_levels = {item.level_a, item.level_b};
   assign code       = {old_entry.levels, cur_levels};
   assign last_a     = old_entry.levels[1];
   assign entry_we   = in_range;

   // work out the channel's next state
   always_comb begin
      new_entry = old_entry;
      red       = 1'b0;
      if (item.cmd == CMD_CLEAR) begin
         new_entry.count = '0;
      end else begin
         case (mode)
            MODE_QUAD: begin
               if (STEP_UP_MASK[code]) begin
                  new_entry.count = old_entry.count + COUNT_W'(1);
               end else if (STEP_DOWN_MASK[code]) begin
                  new_entry.count = old_entry.count - COUNT_W'(1);
               end
               red              = (cur_levels == old_entry.levels);
               new_entry.levels = cur_levels;
            end
            MODE_RISE, MODE_DIR: begin
               if (item.level_a && !last_a) begin
                  if ((mode == MODE_DIR) && item.level_b) begin
                     new_entry.count = old_entry.count - COUNT_W'(1);
                  end else begin
                     new_entry.count = old_entry.count + COUNT_W'(1);
                  end
                  new_entry.levels[1] = 1'b1;
                  new_entry.tally     = '0;
               end else if (!item.level_a && last_a) begin
                  new_entry.levels[1] = 1'b0;
                  new_entry.tally     = '0;
               end else begin
                  red = 1'b1;
                  if (old_entry.tally != TALLY_MAX) begin
                     new_entry.tally = old_entry.tally + TALLY_W'(1);
                  end
               end
            end
            default: begin
               red = 1'b1;
            end
         endcase
      end
   end

   // form the result; zero all but out_channel for a channel beyond the array
   always_comb begin
      result.out_channel = item.channel;
      if (in_range) begin
         result.position  = new_entry.count;
         result.redundant = red;
         result.repeats   = new_entry.tally;
      end else begin
         result.position  = '0;
         result.redundant = 1'b0;
         result.repeats   = '0;
      end
   end

endmodule

FILE: test/multi_mode_rotary_encoder_counter_core_tb.sv
module multi_mode_rotary_encoder_counter_core_tb;
   import mmrec_pkg::*;

   // mode value with no decoding behind it
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1_000_000;
   // length of the run of no-edge samples that builds up the tally
   localparam int TALLY_RUN = 20;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_cmd = CMD_SAMPLE;
   logic [CH_FIELD_W-1:0] req_channel = '0;
   logic                  req_level_a = 1'b0;
   logic                  req_level_b = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CH_FIELD_W-1:0] rsp_out_channel;
   logic signed [COUNT_W-1:0] rsp_position;
   logic                  rsp_redundant;
   logic [TALLY_W-1:0]    rsp_repeats;
   logic                  csr_wr_en = 1'b0;
   logic [MODE_W-1:0]     csr_wr_data = '0;

   // shadow of the encoder state per channel
   logic [COUNT_W-1:0] shadow_count [CHANNELS];
   logic [1:0]         shadow_levels [CHANNELS];
   logic [TALLY_W-1:0] shadow_tally [CHANNELS];
   logic [MODE_W-1:0]  shadow_mode;
   result_type         pending_results [$];

   // pin levels last offered per channel, used to build clean sequences
   logic [1:0] stim_levels [8];

   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;

   multi_mode_rotary_encoder_counter_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_channel     (req_channel),
      .req_level_a     (req_level_a),
      .req_level_b     (req_level_b),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_channel (rsp_out_channel),
      .rsp_position    (rsp_position),
      .rsp_redundant   (rsp_redundant),
      .rsp_repeats     (rsp_repeats),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // step direction for a {previous AB, current AB} transition code
   function automatic int quad_step(input logic [3:0] code);
      case (code)
         4'd13, 4'd4, 4'd2, 4'd11: return 1;
         4'd14, 4'd7, 4'd1, 4'd8: return -1;
         default: return 0;
      endcase
   endfunction

   // advance the shadow state by one item and return the result it causes
   function automatic result_type decode_item(input item_type it);
      result_type r;
      int ch;
      int s;
      logic [1:0] cur;
      logic last_a;
      r.out_channel = it.channel;
      r.position = '0;
      r.redundant = 1'b0;
      r.repeats = '0;
      ch = int'(it.channel);
      if (ch >= CHANNELS) return r;
      if (it.cmd == CMD_CLEAR) begin
         shadow_count[ch] = '0;
      end else if (shadow_mode == MODE_QUAD) begin
         cur = {it.level_a, it.level_b};
         s = quad_step({shadow_levels[ch], cur});
         if (cur == shadow_levels[ch]) r.redundant = 1'b1;
         if (s > 0) shadow_count[ch] = shadow_count[ch] + 1'b1;
         else if (s < 0) shadow_count[ch] = shadow_count[ch] - 1'b1;
         shadow_levels[ch] = cur;
      end else if (shadow_mode == MODE_RISE || shadow_mode == MODE_DIR) begin
         last_a = shadow_levels[ch][1];
         if (it.level_a && !last_a) begin
            if (shadow_mode == MODE_DIR && it.level_b)
               shadow_count[ch] = shadow_count[ch] - 1'b1;
            else
               shadow_count[ch] = shadow_count[ch] + 1'b1;
            shadow_levels[ch][1] = 1'b1;
            shadow_tally[ch] = '0;
         end else if (!it.level_a && last_a) begin
            shadow_levels[ch][1] = 1'b0;
            shadow_tally[ch] = '0;
         end else begin
            r.redundant = 1'b1;
            if (shadow_tally[ch] != TALLY_MAX) shadow_tally[ch] = shadow_tally[ch] + 1'b1;
         end
      end else begin
         r.redundant = 1'b1;
      end
      r.position = shadow_count[ch];
      r.repeats = shadow_tally[ch];
      return r;
   endfunction

   // check each result item, then record each accepted input item
   always @(posedge clock) begin
      result_type want;
      item_type it;
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            shadow_count[i] = '0;
            shadow_levels[i] = '0;
            shadow_tally[i] = '0;
         end
         shadow_mode = MODE_QUAD;
         pending_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result item on channel %0d", rsp_out_channel);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_out_channel !== want.out_channel) begin
                  $error("out_channel: expected %0d, got %0d", want.out_channel,
                         rsp_out_channel);
                  error_count++;
               end
               if (rsp_position !== want.position) begin
                  $error("position: expected %0d, got %0d", $signed(want.position),
                         rsp_position);
                  error_count++;
               end
               if (rsp_redundant !== want.redundant) begin
                  $error("redundant: expected %0d, got %0d", want.redundant, rsp_redundant);
                  error_count++;
               end
               if (rsp_repeats !== want.repeats) begin
                  $error("repeats: expected %0d, got %0d", want.repeats, rsp_repeats);
                  error_count++;
               end
            end
         end
         if (csr_wr_en) shadow_mode = csr_wr_data;
         if (req_valid && req_ready) begin
            it.cmd = req_cmd;
            it.channel = req_channel;
            it.level_a = req_level_a;
            it.level_b = req_level_b;
            pending_results.push_back(decode_item(it));
         end
      end
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // drive the result side ready, with random stalls and long hold-offs
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // offer one item after a random gap and hold it until accepted
   task automatic send_item(input logic cmd, input logic [CH_FIELD_W-1:0] ch,
                            input logic a, input logic b);
      int gap;
      gap = 0;
      while ($urandom_range(99, 0) < send_idle_pct && gap < 40) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_channel <= ch;
      req_level_a <= a;
      req_level_b <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait until every expected result has arrived
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(input logic [MODE_W-1:0] m);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // mostly clean encoder motion, with some repeats, noise and clears
   task automatic send_random_item(input logic [MODE_W-1:0] m);
      logic [CH_FIELD_W-1:0] ch;
      logic [1:0] lv;
      int pick;
      ch = CH_FIELD_W'($urandom_range(7, 0));
      pick = $urandom_range(99, 0);
      lv = stim_levels[ch];
      if (pick < 4) begin
         send_item(CMD_CLEAR, ch, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
         return;
      end
      if (pick < 14) begin
         lv = 2'($urandom_range(3, 0));
      end else if (pick >= 24) begin
         if (m == MODE_QUAD) lv = lv ^ ($urandom_range(1, 0) ? 2'b10 : 2'b01);
         else lv = {~lv[1], 1'($urandom_range(1, 0))};
      end
      stim_levels[ch] = lv;
      send_item(CMD_SAMPLE, ch, lv[1], lv[0]);
   endtask

   task automatic test_quadrature_decode();
      wait_idle();
      write_mode(MODE_QUAD);
      send_item(CMD_SAMPLE, 3'd3, 1'b0, 1'b0);
      send_item(CMD_SAMPLE, 3'd0, 1'b0, 1'b1);
      send_item(CMD_SAMPLE, 3'd0, 1'b1, 1'b1);
      send_item(CMD_SAMPLE, 3'd0, 1'b1, 1'b1);
      send_item(CMD_SAMPLE, 3'd0, 1'b1, 1'b0);
      send_item(CMD_SAMPLE, 3'd0, 1'b0, 1'b0);
      send_item(CMD_SAMPLE, 3'd0, 1'b1, 1'b0);
      send_item(CMD_SAMPLE, 3'd0, 1'b1, 1'b1);
      // double transition: no step
      send_item(CMD_SAMPLE, 3'd0, 1'b0, 1'b0);
      send_item(CMD_SAMPLE, 3'd7, 1'b1, 1'b0);
      send_item(CMD_SAMPLE, 3'd7, 1'b1, 1'b1);
      send_item(CMD_CLEAR, 3'd7, 1'b0, 1'b0);
      send_item(CMD_SAMPLE, 3'd7, 1'b0, 1'b1);
   endtask

   task automatic test_single_pin_count();
      wait_idle();
      write_mode(MODE_RISE);
      send_item(CMD_SAMPLE, 3'd2, 1'b0, 1'b1);
      send_item(CMD_SAMPLE, 3'd2, 1'b0, 1'b0);
      send_item(CMD_SAMPLE, 3'd2, 1'b1, 1'b1);
      send_item(CMD_SAMPLE, 3'd2, 1'b1, 1'b0);
      send_item(CMD_SAMPLE, 3'd2, 1'b0, 1'b1);
      send_item(CMD_SAMPLE, 3'd2, 1'b1, 1'b0);
      send_item(CMD_CLEAR, 3'd2, 1'b1, 1'b1);
   endtask

   task automatic test_direction_count();
      wait_idle();
      write_mode(MODE_DIR);
      send_item(CMD_SAMPLE, 3'd5, 1'b1, 1'b0);
      send_item(CMD_SAMPLE, 3'd5, 1'b0, 1'b0);
      send_item(CMD_SAMPLE, 3'd5, 1'b1, 1'b1);
      send_item(CMD_SAMPLE, 3'd5, 1'b1, 1'b1);
      send_item(CMD_CLEAR, 3'd5, 1'b0, 1'b0);
   endtask

   task automatic test_unused_mode();
      wait_idle();
      write_mode(MODE_UNUSED);
      send_item(CMD_SAMPLE, 3'd0, 1'b1, 1'b1);
      send_item(CMD_SAMPLE, 3'd7, 1'b0, 1'b0);
      send_item(CMD_CLEAR, 3'd0, 1'b0, 1'b1);
   endtask

   // run of samples with no A edge, then an edge to release the tally
   task automatic test_repeat_tally();
      wait_idle();
      write_mode(MODE_RISE);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (TALLY_RUN) send_item(CMD_SAMPLE, 3'd4, 1'b0, 1'($urandom_range(1, 0)));
      send_item(CMD_SAMPLE, 3'd4, 1'b1, 1'b0);
   endtask

   // stall the result side so the block fills and backs up its input
   task automatic test_backpressure();
      wait_idle();
      write_mode(MODE_QUAD);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 300;
      repeat (60) send_random_item(MODE_QUAD);
      wait_idle();
      repeat (20) send_random_item(MODE_QUAD);
   endtask

   // three idle patterns, each going through every mode value
   task automatic test_random_traffic();
      int sender_pct [3] = '{25, 57, 0};
      int receiver_pct [3] = '{57, 25, 0};
      logic [MODE_W-1:0] m;
      for (int p = 0; p < 3; p++) begin
         for (int s = 0; s < 4; s++) begin
            wait_idle();
            send_idle_pct = sender_pct[p];
            recv_idle_pct = receiver_pct[p];
            m = MODE_W'((s + p) % 4);
            write_mode(m);
            repeat ((m == MODE_UNUSED) ? 60 : 160) send_random_item(m);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < 8; i++) stim_levels[i] = 2'b00;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_quadrature_decode();
      test_single_pin_count();
      test_direction_count();
      test_unused_mode();
      test_repeat_tally();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
